### rtl/lsll_pkg.sv
// ----------------------------------------------------------------------------
// lsll_pkg
// Shared widths, register indexes, modes and controller states for the
// latent space log-likelihood accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package lsll_pkg;

  // Q8.16 data words
  localparam int DataW = 24;
  localparam int FracW = 16;

  // running sum and observation count
  localparam int AccW = 48;
  localparam int CntW = 24;

  // squared coordinate difference, exact Q.32
  localparam int SqW = 2 * DataW;

  // softplus: |x| below 16.0 uses the table, lookup fraction has 20 bits
  localparam int SpFracW = FracW + 4;
  localparam int SpW     = DataW + 1;

  // configuration fields
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 24;
  localparam int DimW        = 2;
  localparam int WeightW     = 23;
  localparam int PosN        = 3;

  localparam logic signed [DataW-1:0] OneQ16 = 24'sd65536;

  localparam logic [DimW-1:0]            DimsRst    = 2'd2;
  localparam logic [WeightW-1:0]         GammaRst   = 23'd65536;
  localparam logic [WeightW-1:0]         InvVarRst  = 23'd32768;
  localparam logic signed [DataW-1:0]    MissingRst = 24'sd6488064;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODEL_MODE   = 3'd0,
    CFG_DIMS_USED    = 3'd1,
    CFG_DIST_WEIGHT  = 3'd2,
    CFG_INV_TWO_VAR  = 3'd3,
    CFG_MISSING_CODE = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOGISTIC = 1'b0,
    MODE_GAUSSIAN = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQRT,
    ST_GD,
    ST_ETA,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_ACC
  } state_e;

endpackage

`default_nettype wire

### rtl/lsll_lane.sv
// ----------------------------------------------------------------------------
// lsll_lane
// One latent dimension: difference of person and item coordinate, squared.
// ----------------------------------------------------------------------------
`default_nettype none

module lsll_lane (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [lsll_pkg::DataW-1:0] person_pos_i,
  input  logic signed [lsll_pkg::DataW-1:0] item_pos_i,
  output logic        [lsll_pkg::SqW-1:0]   sq_o
);
  import lsll_pkg::*;

  logic signed [DataW:0] diff;
  logic        [DataW:0] mag;
  logic        [SqW-1:0] sq_q;

  always_comb begin
    diff = (DataW+1)'(person_pos_i) - (DataW+1)'(item_pos_i);
    mag  = diff[DataW] ? (DataW+1)'(-diff) : (DataW+1)'(diff);
  end

  // magnitude never exceeds 2^24 - 1
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= mag[DataW-1:0] * mag[DataW-1:0];
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

### rtl/lsll_isqrt.sv
// ----------------------------------------------------------------------------
// lsll_isqrt
// Rounded-down integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsll_isqrt #(
  parameter  int OpW   = 50,
  localparam int RootW = (OpW + 1) / 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   op_i,
  output logic [RootW-1:0] root_o,
  output logic             done_o
);
  import lsll_pkg::*;

  localparam int W    = OpW + 1;
  localparam int StCw = $clog2(RootW + 1);

  logic [W-1:0]    n_q, r_q, bit_q, trial;
  logic [StCw-1:0] cnt_q;
  logic            busy_q, done_q;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= StCw'(RootW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StCw'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring root: operand below 4^RootW, start at the top power of four
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= W'(op_i);
      r_q   <= '0;
      bit_q <= W'(1) << (2 * (RootW - 1));
    end else if (busy_q) begin
      if (n_q >= trial) begin
        n_q <= n_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[RootW-1:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

### rtl/lsll_softplus.sv
// ----------------------------------------------------------------------------
// lsll_softplus
// Softplus by linear interpolation in a ln(1 + exp(-u)) table, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lsll_softplus #(
  parameter int Entries = 1024
) (
  input  logic                              clk_i,
  input  logic signed [lsll_pkg::DataW:0]   x_i,
  output logic        [lsll_pkg::SpW-1:0]   sp_o
);
  import lsll_pkg::*;

  localparam int IdxW = $clog2(Entries + 1);
  localparam int PW   = SpFracW + IdxW;
  localparam logic [63:0] One62 = 64'd1 << 62;

  typedef logic [FracW-1:0] rom_t [Entries+1];

  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  // exp(-f) in Q62, f in [0, 1]
  function automatic logic [63:0] exp_neg62(input logic [63:0] f);
    logic [63:0] acc, term;
    acc  = One62;
    term = One62;
    for (int m = 1; m <= 40; m++) begin
      term = mul_shr(term, f, 62) / 64'(m);
      if (m[0]) acc = acc - term;
      else      acc = acc + term;
    end
    return acc;
  endfunction

  // entry k: round(65536 * ln(1 + exp(-16k/Entries))), 62-bit fraction maths
  function automatic rom_t build_rom();
    rom_t        tab;
    logic [63:0] ln2, e1, q, n, r, hi, rem, f, y, x, lg, ln48;
    ln2 = '0;
    for (int k = 1; k <= 61; k++) begin
      ln2 = ln2 + ((64'd1 << (62 - k)) / 64'(k));
    end
    e1 = exp_neg62(One62);
    for (int k = 0; k <= Entries; k++) begin
      q   = 64'(k) * 64'd16;
      n   = q / Entries;
      r   = q % Entries;
      hi  = (r << 50) / Entries;
      rem = (r << 50) % Entries;
      f   = (hi << 12) + ((rem << 12) / Entries);
      y   = exp_neg62(f);
      for (int j = 0; 64'(j) < n; j++) begin
        y = mul_shr(y, e1, 62);
      end
      x  = (One62 + y) >> 1;
      lg = '0;
      if (x >= One62) begin
        lg = 64'd1 << 48;
      end else begin
        for (int j = 47; j >= 0; j--) begin
          x = mul_shr(x, x, 61);
          if (x >= One62) begin
            x     = x >> 1;
            lg[j] = 1'b1;
          end
        end
      end
      ln48   = mul_shr(lg, ln2, 62);
      tab[k] = FracW'((ln48 + (64'd1 << 31)) >> 32);
    end
    return tab;
  endfunction

  localparam rom_t SpRom = build_rom();

  logic        [DataW:0]     u;
  logic        [PW-1:0]      p;
  logic                      rng;

  logic        [IdxW-1:0]    idx0_q;
  logic        [SpFracW-1:0] fr0_q, fr1_q;
  logic signed [DataW:0]     x0_q, x1_q, x2_q;
  logic                      rng0_q, rng1_q, rng2_q;
  logic        [FracW-1:0]   t0_q, t1_q, t2_q;
  logic signed [FracW:0]     d;
  logic signed [FracW+SpFracW+1:0] prod_q;
  logic signed [FracW+1:0]   s;
  logic        [FracW-1:0]   s_mag;
  logic        [SpW-1:0]     sp_d, sp_q;
  logic                      x_pos;

  always_comb begin
    u   = x_i[DataW] ? (DataW+1)'(-x_i) : (DataW+1)'(x_i);
    rng = (u[DataW:SpFracW] == '0);
    p   = PW'(u[SpFracW-1:0]) * PW'(Entries);
  end

  // stage 0: table position, stage 1: registered table reads
  always_ff @(posedge clk_i) begin
    idx0_q <= p[PW-1:SpFracW];
    fr0_q  <= p[SpFracW-1:0];
    x0_q   <= x_i;
    rng0_q <= rng;

    t0_q   <= SpRom[idx0_q];
    t1_q   <= SpRom[IdxW'(idx0_q + 1'b1)];
    fr1_q  <= fr0_q;
    x1_q   <= x0_q;
    rng1_q <= rng0_q;
  end

  assign d = $signed({1'b0, t1_q}) - $signed({1'b0, t0_q});

  // stage 2: slope times fraction
  always_ff @(posedge clk_i) begin
    prod_q <= d * $signed({1'b0, fr1_q});
    t2_q   <= t0_q;
    x2_q   <= x1_q;
    rng2_q <= rng1_q;
  end

  // stage 3: floor of the interpolation, then x + s for positive x
  always_comb begin
    s     = $signed({2'b00, t2_q}) + $signed(prod_q[FracW+SpFracW+1:SpFracW]);
    s_mag = rng2_q ? s[FracW-1:0] : '0;
    x_pos = !x2_q[DataW] && (x2_q != '0);
    sp_d  = x_pos ? SpW'(x2_q) + SpW'(s_mag) : SpW'(s_mag);
  end

  always_ff @(posedge clk_i) begin
    sp_q <= sp_d;
  end

  assign sp_o = sp_q;

endmodule

`default_nettype wire

### rtl/latent_space_irt_loglik_accumulator.sv
// ----------------------------------------------------------------------------
// latent_space_irt_loglik_accumulator
// Latent space item response log-likelihood: distance lanes, a merging root
// stage, eta, logistic or Gaussian term and a saturating running sum.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+------------------------------------
//  in      | in  | in_valid_i/in_stall_o | response, beta, alpha, theta,
//          |     |                      | positions a..c, last_obs
//  out     | out | out_valid_o/out_stall_i | loglik_sum, obs_counted, is_final
//  cfg     | in  | cfg_valid_i/cfg_ready_o | register index, write data
//
//  one word in flight: the next word is accepted only once the controller is
//  back in idle; the square root unit, which resolves one root bit per cycle
//  over the merged sum of squares, holds the controller in its root state
//  the result register is separate, so the next word is taken while a
//  result waits; a held result only stretches the final accumulate state
//  reset clears the sum, the count, the controller and the registers to
//  their listed defaults; the cfg port is always ready
//
`default_nettype none

module latent_space_irt_loglik_accumulator #(
  parameter int MAX_DIM          = 3,
  parameter int SOFTPLUS_ENTRIES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [lsll_pkg::DataW-1:0]    response_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_easiness_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_slope_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_ability_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_pos_a_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_pos_b_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_pos_c_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_pos_a_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_pos_b_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_pos_c_i,
  input  logic                                 last_obs_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lsll_pkg::AccW-1:0]     loglik_sum_o,
  output logic        [lsll_pkg::CntW-1:0]     obs_counted_o,
  output logic                                 is_final_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [lsll_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [lsll_pkg::CfgDataW-1:0] cfg_data_i
);
  import lsll_pkg::*;

  // distance widths follow the number of lanes
  localparam int SumW   = SqW + $clog2(MAX_DIM);
  localparam int RootW  = (SumW + 1) / 2;
  localparam int AtW    = 2 * DataW - FracW;
  localparam int GdW    = WeightW + RootW - FracW;
  localparam int EtaW   = ((GdW > AtW) ? GdW : AtW) + 2;
  // Gaussian path: |e| below 2^24, squared, shifted, times 1/(2 sigma^2)
  localparam int GsqW   = 2 * (DataW + 1);
  localparam int GsW    = GsqW - FracW;
  localparam int GprodW = GsW + WeightW;
  localparam int TermW  = GprodW - FracW;

  // controller
  state_e state_q, state_d;
  logic   in_accept, sqrt_start, out_load, sqrt_done;

  // configuration registers
  mode_e                    mode_q;
  logic [DimW-1:0]          dims_q;
  logic [WeightW-1:0]       gamma_q, inv_q;
  logic signed [DataW-1:0]  miss_q;

  // captured word
  logic signed [DataW-1:0]  resp_q, beta_q, alpha_q, theta_q;
  logic                     last_q;

  // lanes and merge
  logic signed [DataW-1:0]  pp [PosN];
  logic signed [DataW-1:0]  ip [PosN];
  logic        [SqW-1:0]    lane_sq [MAX_DIM];
  logic        [SumW-1:0]   sum_sq;
  logic        [RootW-1:0]  root;

  // eta
  logic signed [2*DataW-1:0]         at_prod;
  logic signed [AtW-1:0]             at_q;
  logic        [WeightW+RootW-1:0]   gd_prod;
  logic        [GdW-1:0]             gd_q;
  logic signed [EtaW-1:0]            eta_sum;
  logic        [EtaW-DataW:0]        eta_hi;
  logic signed [DataW-1:0]           eta_d, eta_q;

  // terms
  logic                     success, missing;
  logic signed [DataW:0]    eta_x, sp_x, gerr;
  logic        [DataW:0]    gabs;
  logic        [GsqW-1:0]   gsq_q;
  logic        [GprodW-1:0] gprod_q;
  logic        [SpW-1:0]    sp;
  logic        [TermW-1:0]  mag;

  // running sum
  logic signed [AccW-1:0]   acc_q, acc_new;
  logic signed [AccW:0]     acc_sum;
  logic        [CntW-1:0]   cnt_q, cnt_new;

  // result register
  logic                     out_valid_q, out_final_q;
  logic signed [AccW-1:0]   out_sum_q;
  logic        [CntW-1:0]   out_cnt_q;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_LOGISTIC;
      dims_q  <= DimsRst;
      gamma_q <= GammaRst;
      inv_q   <= InvVarRst;
      miss_q  <= MissingRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MODEL_MODE:   mode_q  <= mode_e'(cfg_data_i[0]);
        CFG_DIMS_USED:    dims_q  <= cfg_data_i[DimW-1:0];
        CFG_DIST_WEIGHT:  gamma_q <= cfg_data_i[WeightW-1:0];
        CFG_INV_TWO_VAR:  inv_q   <= cfg_data_i[WeightW-1:0];
        CFG_MISSING_CODE: miss_q  <= $signed(cfg_data_i[DataW-1:0]);
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // ------------------------------------------------------------ controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_SQRT;
      ST_SQRT: if (sqrt_done) state_d = ST_GD;
      ST_GD:   state_d = ST_ETA;
      ST_ETA:  state_d = ST_T1;
      ST_T1:   state_d = ST_T2;
      ST_T2:   state_d = ST_T3;
      ST_T3:   state_d = ST_T4;
      ST_T4:   state_d = ST_ACC;
      ST_ACC:  if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    sqrt_start = (state_q == ST_LOAD);
    out_load   = (state_q == ST_ACC) && (!out_valid_q || !out_stall_i);
  end

  // ---------------------------------------------------------- word capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      resp_q  <= response_i;
      beta_q  <= item_easiness_i;
      alpha_q <= item_slope_i;
      theta_q <= person_ability_i;
      last_q  <= last_obs_i;
    end
  end

  // ----------------------------------------------------- distance lanes
  assign pp[0] = person_pos_a_i;
  assign pp[1] = person_pos_b_i;
  assign pp[2] = person_pos_c_i;
  assign ip[0] = item_pos_a_i;
  assign ip[1] = item_pos_b_i;
  assign ip[2] = item_pos_c_i;

  for (genvar g = 0; g < MAX_DIM; g++) begin : g_lane
    lsll_lane u_lane (
      .clk_i        (clk_i),
      .en_i         (in_accept),
      .person_pos_i (pp[g]),
      .item_pos_i   (ip[g]),
      .sq_o         (lane_sq[g])
    );
  end

  // merge: only the dimensions in use, capped at the lane count
  always_comb begin
    sum_sq = '0;
    for (int j = 0; j < MAX_DIM; j++) begin
      if (DimW'(j) < dims_q) sum_sq = sum_sq + SumW'(lane_sq[j]);
    end
  end

  lsll_isqrt #(
    .OpW (SumW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .op_i    (sum_sq),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // ------------------------------------------------------------------- eta
  // free running: captured operands hold for the whole word, the root once done
  assign at_prod = alpha_q * theta_q;
  assign gd_prod = gamma_q * root;

  always_comb begin
    eta_sum = EtaW'(beta_q) + EtaW'(at_q) - EtaW'(gd_q);
    eta_hi  = eta_sum[EtaW-1:DataW-1];
    if ((&eta_hi) || !(|eta_hi)) begin
      eta_d = eta_sum[DataW-1:0];
    end else if (eta_sum[EtaW-1]) begin
      eta_d = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      eta_d = {1'b0, {(DataW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    at_q  <= at_prod[2*DataW-1:FracW];   // floor of alpha*theta
    gd_q  <= gd_prod[WeightW+RootW-1:FracW];
    eta_q <= eta_d;
  end

  // ------------------------------------------------------------------ terms
  always_comb begin
    success = (resp_q == OneQ16);
    missing = (resp_q == miss_q);
    eta_x   = (DataW+1)'(eta_q);
    sp_x    = success ? -eta_x : eta_x;
    gerr    = (DataW+1)'(resp_q) - (DataW+1)'(eta_q);
    gabs    = gerr[DataW] ? (DataW+1)'(-gerr) : (DataW+1)'(gerr);
  end

  lsll_softplus #(
    .Entries (SOFTPLUS_ENTRIES)
  ) u_softplus (
    .clk_i (clk_i),
    .x_i   (sp_x),
    .sp_o  (sp)
  );

  always_ff @(posedge clk_i) begin
    gsq_q   <= gabs * gabs;
    gprod_q <= gsq_q[GsqW-1:FracW] * inv_q;
  end

  // ------------------------------------------------------------ accumulate
  always_comb begin
    mag = (mode_q == MODE_GAUSSIAN) ? gprod_q[GprodW-1:FracW] : TermW'(sp);
    acc_sum = {acc_q[AccW-1], acc_q} - (AccW+1)'(mag);
    if (missing) begin
      acc_new = acc_q;
    end else if (acc_sum[AccW] && !acc_sum[AccW-1]) begin
      acc_new = {1'b1, {(AccW-1){1'b0}}};   // floor of the sum
    end else begin
      acc_new = acc_sum[AccW-1:0];
    end
    if (missing || (&cnt_q)) begin
      cnt_new = cnt_q;
    end else begin
      cnt_new = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
    end else if (out_load) begin
      acc_q <= last_q ? '0 : acc_new;
      cnt_q <= last_q ? '0 : cnt_new;
    end
  end

  // ---------------------------------------------------------- result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sum_q   <= acc_new;
      out_cnt_q   <= cnt_new;
      out_final_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign loglik_sum_o  = out_sum_q;
  assign obs_counted_o = out_cnt_q;
  assign is_final_o    = out_final_q;

`ifndef SYNTH
  a_acc_nonpos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q[AccW-1] || (acc_q == '0))
    else $error("running sum became positive");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_q && out_stall_i))
    else $error("held result overwritten");

  a_final_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (acc_q == '0) && (cnt_q == '0))
    else $error("sum not cleared after final word");

  a_root_timing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == ST_SQRT))
    else $error("root finished outside the root state");
`endif

endmodule

`default_nettype wire

### bench/lsll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsll_checker
// Watches the observation, result and register channels of the accumulator,
// keeps its own copy of the registers and the running sum, and compares each
// result word with the predicted one.
// ----------------------------------------------------------------------------

module lsll_checker #(
  parameter int MAX_DIM          = 3,
  parameter int SOFTPLUS_ENTRIES = 1024
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [lsll_pkg::DataW-1:0]    response_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_easiness_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_slope_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_ability_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_pos_a_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_pos_b_i,
  input  logic signed [lsll_pkg::DataW-1:0]    person_pos_c_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_pos_a_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_pos_b_i,
  input  logic signed [lsll_pkg::DataW-1:0]    item_pos_c_i,
  input  logic                                 last_obs_i,

  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [lsll_pkg::AccW-1:0]     loglik_sum_i,
  input  logic        [lsll_pkg::CntW-1:0]     obs_counted_i,
  input  logic                                 is_final_i,

  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic        [lsll_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [lsll_pkg::CfgDataW-1:0] cfg_data_i,

  output int                                   fail_count_o,
  output logic                                 idle_o
);
  import lsll_pkg::*;

  localparam logic [63:0] OneQ62   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] SpN      = SOFTPLUS_ENTRIES;
  localparam longint      AccFloor = -(longint'(1) << 47);

  typedef struct {
    logic signed [AccW-1:0] sum;
    logic [CntW-1:0]        cnt;
    logic                   fin;
  } loglik_word_t;

  // register copy
  mode_e                     mode_q = MODE_LOGISTIC;
  logic [DimW-1:0]           dims_q = DimsRst;
  logic [WeightW-1:0]        gamma_q = GammaRst;
  logic [WeightW-1:0]        inv_var_q = InvVarRst;
  logic signed [DataW-1:0]   missing_q = MissingRst;

  // running sum and count
  longint                    loglik_acc = 0;
  logic [CntW-1:0]           obs_cnt = '0;

  loglik_word_t              sums_due [$];
  loglik_word_t              want;
  logic [63:0]               sp_lut [0:SOFTPLUS_ENTRIES];
  logic [63:0]               dist_q16;
  longint                    eta, term;
  int                        errors = 0;

  assign fail_count_o = errors;

  // low 64 bits of (a*b) >> sh
  function automatic logic [63:0] mulhi_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  // exp(-f) in Q62, f in [0,1]
  function automatic logic [63:0] exp_neg_q62(logic [63:0] f);
    logic [63:0] acc, step;
    int m;
    acc  = OneQ62;
    step = OneQ62;
    for (m = 1; m <= 40; m++) begin
      step = mulhi_shift(step, f, 62) / 64'(m);
      if (m % 2 == 1) acc = acc - step;
      else acc = acc + step;
    end
    return acc;
  endfunction

  // softplus samples over [0,16], Q16, rounded to nearest
  function automatic void fill_softplus_lut();
    logic [63:0] ln2, e1, q, n, r, hi, rem, f, y, x, lg, ln48;
    int k, j;
    ln2 = '0;
    for (k = 1; k <= 61; k++) ln2 = ln2 + ((64'd1 << (62 - k)) / 64'(k));
    e1 = exp_neg_q62(OneQ62);
    for (k = 0; k <= SOFTPLUS_ENTRIES; k++) begin
      q   = 64'(k) * 64'd16;
      n   = q / SpN;
      r   = q % SpN;
      hi  = (r << 50) / SpN;
      rem = (r << 50) % SpN;
      f   = (hi << 12) + ((rem << 12) / SpN);
      y   = exp_neg_q62(f);
      for (j = 0; j < n; j++) y = mulhi_shift(y, e1, 62);
      x  = (OneQ62 + y) >> 1;
      lg = '0;
      if (x >= OneQ62) begin
        lg = 64'd1 << 48;
      end else begin
        // binary log by repeated squaring
        for (j = 47; j >= 0; j--) begin
          x = mulhi_shift(x, x, 61);
          if (x >= OneQ62) begin
            x     = x >> 1;
            lg[j] = 1'b1;
          end
        end
      end
      ln48      = mulhi_shift(lg, ln2, 62);
      sp_lut[k] = (ln48 + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] root, probe;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic longint softplus_fix(longint x);
    longint u, s, p, idx, fr, d;
    u = (x < 0) ? -x : x;
    s = 0;
    if (u < (longint'(16) << 16)) begin
      p   = u * SOFTPLUS_ENTRIES;
      idx = p >>> 20;
      fr  = p & 64'hF_FFFF;
      d   = longint'(sp_lut[idx+1]) - longint'(sp_lut[idx]);
      s   = longint'(sp_lut[idx]) + ((d * fr) >>> 20);
    end
    return (x > 0) ? x + s : s;
  endfunction

  function automatic logic [63:0] latent_distance(longint da, longint db, longint dc);
    longint      span [3];
    logic [63:0] sq;
    int          nd, j;
    span[0] = da;
    span[1] = db;
    span[2] = dc;
    nd = (int'(dims_q) > MAX_DIM) ? MAX_DIM : int'(dims_q);
    sq = '0;
    for (j = 0; j < nd && j < PosN; j++) sq = sq + 64'(span[j] * span[j]);
    return int_root(sq);
  endfunction

  function automatic longint eta_of(longint beta, longint alpha, longint theta,
                                    logic [63:0] dq);
    longint e;
    e = beta + ((alpha * theta) >>> FracW)
        - ((longint'(gamma_q) * longint'(dq)) >>> FracW);
    if (e > 64'sd8388607) e = 64'sd8388607;
    if (e < -64'sd8388608) e = -64'sd8388608;
    return e;
  endfunction

  function automatic longint obs_term(longint resp, longint e_val);
    longint err, s16;
    if (mode_q == MODE_LOGISTIC) begin
      return -softplus_fix((resp == longint'(OneQ16)) ? -e_val : e_val);
    end
    err = resp - e_val;
    if (err < 0) err = -err;
    s16 = (err * err) >>> FracW;
    return -((s16 * longint'(inv_var_q)) >>> FracW);
  endfunction

  initial fill_softplus_lut();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     = MODE_LOGISTIC;
      dims_q     = DimsRst;
      gamma_q    = GammaRst;
      inv_var_q  = InvVarRst;
      missing_q  = MissingRst;
      loglik_acc = 0;
      obs_cnt    = '0;
      sums_due.delete();
      idle_o <= 1'b1;
    end else begin
      // result word first: it can never belong to a word taken at this edge
      if (out_valid_i && !out_stall_i) begin
        if (sums_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result word: sum %0d count %0d final %0b",
                     loglik_sum_i, obs_counted_i, is_final_i);
        end else begin
          want = sums_due.pop_front();
          if (want.sum !== loglik_sum_i || want.cnt !== obs_counted_i ||
              want.fin !== is_final_i) begin
            errors++;
            if (errors <= 10)
              $display("result mismatch: expected sum %0d count %0d final %0b, got sum %0d count %0d final %0b",
                       want.sum, want.cnt, want.fin,
                       loglik_sum_i, obs_counted_i, is_final_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        dist_q16 = latent_distance(
            longint'(person_pos_a_i) - longint'(item_pos_a_i),
            longint'(person_pos_b_i) - longint'(item_pos_b_i),
            longint'(person_pos_c_i) - longint'(item_pos_c_i));
        eta = eta_of(longint'(item_easiness_i), longint'(item_slope_i),
                     longint'(person_ability_i), dist_q16);
        if (response_i != missing_q) begin
          term       = obs_term(longint'(response_i), eta);
          loglik_acc = loglik_acc + term;
          if (loglik_acc < AccFloor) loglik_acc = AccFloor;
          if (obs_cnt != '1) obs_cnt = obs_cnt + 1'b1;
        end
        want.sum = loglik_acc[AccW-1:0];
        want.cnt = obs_cnt;
        want.fin = last_obs_i;
        sums_due.push_back(want);
        if (last_obs_i) begin
          loglik_acc = 0;
          obs_cnt    = '0;
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MODEL_MODE:   mode_q = mode_e'(cfg_data_i[0]);
          CFG_DIMS_USED:    dims_q = cfg_data_i[DimW-1:0];
          CFG_DIST_WEIGHT:  gamma_q = cfg_data_i[WeightW-1:0];
          CFG_INV_TWO_VAR:  inv_var_q = cfg_data_i[WeightW-1:0];
          CFG_MISSING_CODE: missing_q = cfg_data_i;
          default: ;
        endcase
      end

      idle_o <= (sums_due.size() == 0);
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the latent space log-likelihood accumulator: a
// directed set of corner observations, then random observation lists under
// several register settings and idling patterns, with a saturating long list
// at the end. Checking is done by lsll_checker beside the block.
// ----------------------------------------------------------------------------

module tb_top;
  import lsll_pkg::*;

  localparam int MaxDim    = 3;
  localparam int SpEntries = 1024;
  localparam int StuckMax  = 4000;

  // handy Q8.16 values
  localparam logic signed [DataW-1:0] QZero    = 24'sh000000;
  localparam logic signed [DataW-1:0] QHalf    = 24'sh008000;
  localparam logic signed [DataW-1:0] QTwo     = 24'sh020000;
  localparam logic signed [DataW-1:0] QSixteen = 24'sh100000;
  localparam logic signed [DataW-1:0] QNegOne  = 24'shFFFFFF;
  localparam logic signed [DataW-1:0] QMax     = 24'sh7FFFFF;
  localparam logic signed [DataW-1:0] QMin     = 24'sh800000;
  localparam logic [WeightW-1:0]      WMax     = '1;

  typedef struct {
    logic signed [DataW-1:0] resp;
    logic signed [DataW-1:0] beta;
    logic signed [DataW-1:0] alpha;
    logic signed [DataW-1:0] theta;
    logic signed [DataW-1:0] pa, pb, pc;
    logic signed [DataW-1:0] ia, ib, ic;
    logic                    last;
  } obs_t;

  typedef struct {
    mode_e                   mode;
    logic [DimW-1:0]         dims;
    logic [WeightW-1:0]      gamma;
    logic [WeightW-1:0]      inv;
    logic signed [DataW-1:0] miss;
  } reg_set_t;

  logic clk_i;
  logic rst_ni;

  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [DataW-1:0] response_i, item_easiness_i, item_slope_i, person_ability_i;
  logic signed [DataW-1:0] person_pos_a_i, person_pos_b_i, person_pos_c_i;
  logic signed [DataW-1:0] item_pos_a_i, item_pos_b_i, item_pos_c_i;
  logic                    last_obs_i;

  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [AccW-1:0]  loglik_sum_o;
  logic [CntW-1:0]         obs_counted_o;
  logic                    is_final_o;

  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i;
  logic [CfgDataW-1:0]     cfg_data_i;

  int                      fail_count;
  logic                    chk_idle;

  // idling pattern, percent of cycles
  int                      idle_pct = 0;
  int                      stall_pct = 0;
  int                      stuck_cycles = 0;
  reg_set_t                cur;

  latent_space_irt_loglik_accumulator #(
    .MAX_DIM          (MaxDim),
    .SOFTPLUS_ENTRIES (SpEntries)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .response_i       (response_i),
    .item_easiness_i  (item_easiness_i),
    .item_slope_i     (item_slope_i),
    .person_ability_i (person_ability_i),
    .person_pos_a_i   (person_pos_a_i),
    .person_pos_b_i   (person_pos_b_i),
    .person_pos_c_i   (person_pos_c_i),
    .item_pos_a_i     (item_pos_a_i),
    .item_pos_b_i     (item_pos_b_i),
    .item_pos_c_i     (item_pos_c_i),
    .last_obs_i       (last_obs_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .loglik_sum_o     (loglik_sum_o),
    .obs_counted_o    (obs_counted_o),
    .is_final_o       (is_final_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  lsll_checker #(
    .MAX_DIM          (MaxDim),
    .SOFTPLUS_ENTRIES (SpEntries)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .response_i       (response_i),
    .item_easiness_i  (item_easiness_i),
    .item_slope_i     (item_slope_i),
    .person_ability_i (person_ability_i),
    .person_pos_a_i   (person_pos_a_i),
    .person_pos_b_i   (person_pos_b_i),
    .person_pos_c_i   (person_pos_c_i),
    .item_pos_a_i     (item_pos_a_i),
    .item_pos_b_i     (item_pos_b_i),
    .item_pos_c_i     (item_pos_c_i),
    .last_obs_i       (last_obs_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .loglik_sum_i     (loglik_sum_o),
    .obs_counted_i    (obs_counted_o),
    .is_final_i       (is_final_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .idle_o           (chk_idle)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles in which no word moves on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= StuckMax) begin
      $display("timeout: no word moved for %0d cycles", StuckMax);
      $display("** latent_space_irt_loglik_accumulator: FAILED **");
      $finish;
    end
  end

  // mostly modest magnitudes so eta lands in the softplus table range,
  // with full-range values and extremes mixed in
  function automatic logic signed [DataW-1:0] rand_q16();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return 24'($urandom_range(0, 1048575)) - 24'd524288;
    if (pick < 82) return 24'($urandom);
    case ($urandom_range(5))
      0: return QMax;
      1: return QMin;
      2: return QZero;
      3: return QNegOne;
      4: return OneQ16;
      default: return -OneQ16;
    endcase
  endfunction

  function automatic obs_t obs_of(logic signed [DataW-1:0] resp, beta, alpha, theta,
                                  ppos, ipos, logic last);
    obs_t o;
    o.resp  = resp;
    o.beta  = beta;
    o.alpha = alpha;
    o.theta = theta;
    o.pa = ppos; o.pb = ppos; o.pc = ppos;
    o.ia = ipos; o.ib = ipos; o.ic = ipos;
    o.last = last;
    return o;
  endfunction

  function automatic obs_t random_obs(logic last);
    obs_t o;
    int   r;
    r = $urandom_range(99);
    if (r < 10) o.resp = cur.miss;
    else if (cur.mode == MODE_LOGISTIC && r < 50) o.resp = OneQ16;
    else if (cur.mode == MODE_LOGISTIC && r < 75) o.resp = QZero;
    else o.resp = rand_q16();
    o.beta  = rand_q16();
    o.alpha = ($urandom_range(99) < 40) ? OneQ16 : rand_q16();
    o.theta = rand_q16();
    o.pa = rand_q16(); o.pb = rand_q16(); o.pc = rand_q16();
    o.ia = rand_q16(); o.ib = rand_q16(); o.ic = rand_q16();
    o.last = last;
    return o;
  endfunction

  // one observation word; valid stays high into the next word unless a gap
  // is drawn, so it is never dropped and raised in the same step
  task automatic send_obs(input obs_t o);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    response_i       <= o.resp;
    item_easiness_i  <= o.beta;
    item_slope_i     <= o.alpha;
    person_ability_i <= o.theta;
    person_pos_a_i   <= o.pa;
    person_pos_b_i   <= o.pb;
    person_pos_c_i   <= o.pc;
    item_pos_a_i     <= o.ia;
    item_pos_b_i     <= o.ib;
    item_pos_c_i     <= o.ic;
    last_obs_i       <= o.last;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // drain: every predicted result word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (!chk_idle);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // unused upper bits carry noise, the block keeps only the field width
  task automatic apply_settings(input reg_set_t s);
    write_reg(CFG_MODEL_MODE, {23'($urandom), s.mode});
    write_reg(CFG_DIMS_USED, {22'($urandom), s.dims});
    write_reg(CFG_DIST_WEIGHT, {1'($urandom), s.gamma});
    write_reg(CFG_INV_TWO_VAR, {1'($urandom), s.inv});
    write_reg(CFG_MISSING_CODE, s.miss);
    cfg_valid_i <= 1'b0;
    cur = s;
  endtask

  initial begin
    reg_set_t s;
    obs_t     o;
    int       p, sent, len, k;

    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    response_i       <= '0;
    item_easiness_i  <= '0;
    item_slope_i     <= '0;
    person_ability_i <= '0;
    person_pos_a_i   <= '0;
    person_pos_b_i   <= '0;
    person_pos_c_i   <= '0;
    item_pos_a_i     <= '0;
    item_pos_b_i     <= '0;
    item_pos_c_i     <= '0;
    last_obs_i       <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= CFG_MODEL_MODE;
    cfg_data_i       <= '0;
    cur.mode  = MODE_LOGISTIC;
    cur.dims  = DimsRst;
    cur.gamma = GammaRst;
    cur.inv   = InvVarRst;
    cur.miss  = MissingRst;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed, first under the reset settings ----
    // eta of zero, then a success, then one lsb off a success
    send_obs(obs_of(QZero, QZero, OneQ16, QZero, QZero, QZero, 1'b0));
    send_obs(obs_of(OneQ16, QTwo, OneQ16, QHalf, OneQ16, QHalf, 1'b0));
    send_obs(obs_of(OneQ16 + 24'sd1, QTwo, OneQ16, QHalf, OneQ16, QHalf, 1'b0));
    // response equal to the reset missing code
    send_obs(obs_of(MissingRst, QTwo, OneQ16, QHalf, OneQ16, QHalf, 1'b0));
    // eta clipped high, then clipped low with a far-apart pair of positions
    send_obs(obs_of(QZero, QMax, QMax, QMax, QZero, QZero, 1'b0));
    send_obs(obs_of(OneQ16, QMin, QMax, QMin, QMax, QMin, 1'b0));
    send_obs(obs_of(QMin, QMin, QMin, QMin, QMin, QMax, 1'b1));
    // edge of the softplus table at |eta| = 16.0
    send_obs(obs_of(QZero, QSixteen, QZero, QZero, QZero, QZero, 1'b0));
    send_obs(obs_of(QZero, QSixteen - 24'sd1, QZero, QZero, QZero, QZero, 1'b0));
    send_obs(obs_of(QZero, -QSixteen, QZero, QZero, QZero, QZero, 1'b0));
    send_obs(obs_of(QMax, QMax, QMax, QMax, QMax, QMax, 1'b1));
    wait_drained();

    // gaussian, no dimensions, heaviest weights, missing code at the floor
    s.mode = MODE_GAUSSIAN; s.dims = 2'd0; s.gamma = WMax; s.inv = WMax; s.miss = QMin;
    apply_settings(s);
    send_obs(obs_of(QMin, QZero, OneQ16, QZero, QZero, QZero, 1'b0));
    send_obs(obs_of(QMax, QMin, QMax, QMin, QMax, QMin, 1'b0));
    send_obs(obs_of(QZero, QZero, OneQ16, QZero, QZero, QZero, 1'b0));
    send_obs(obs_of(QNegOne, QHalf, OneQ16, QTwo, QHalf, QNegOne, 1'b1));
    wait_drained();

    // logistic, all three dimensions, zero weights, missing code at the top
    s.mode = MODE_LOGISTIC; s.dims = 2'd3; s.gamma = '0; s.inv = '0; s.miss = QMax;
    apply_settings(s);
    send_obs(obs_of(QZero, QZero, OneQ16, QZero, QMax, QMin, 1'b0));
    send_obs(obs_of(QMax, QZero, OneQ16, QZero, QMax, QMin, 1'b0));
    send_obs(obs_of(QNegOne, QHalf, QNegOne, QTwo, QZero, QHalf, 1'b1));
    wait_drained();

    // one dimension, zero as the missing code
    s.mode = MODE_LOGISTIC; s.dims = 2'd1; s.gamma = GammaRst; s.inv = InvVarRst;
    s.miss = QZero;
    apply_settings(s);
    send_obs(obs_of(QZero, QTwo, OneQ16, QHalf, QTwo, QZero, 1'b0));
    send_obs(obs_of(OneQ16, QZero, OneQ16, QZero, QTwo, -QTwo, 1'b1));
    wait_drained();

    // ---- random lists under changing settings and idling patterns ----
    for (p = 0; p < 8; p++) begin
      s.mode  = (p % 2 == 1) ? MODE_GAUSSIAN : MODE_LOGISTIC;
      s.dims  = DimW'(p % 4);
      s.gamma = (p == 2) ? '0 : (p == 5) ? WMax : WeightW'($urandom_range(0, 262144));
      s.inv   = (p == 3) ? '0 : (p == 7) ? WMax : WeightW'($urandom_range(0, 131072));
      s.miss  = (p == 1) ? QMin : (p == 4) ? QMax : (p == 6) ? MissingRst : rand_q16();
      apply_settings(s);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      // lists of random length; a phase may end mid-list, so the sum runs on
      sent = 0;
      while (sent < 72) begin
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++) begin
          o = random_obs((k == len - 1) && ($urandom_range(9) != 0));
          send_obs(o);
        end
        sent += len;
      end
      wait_drained();
    end

    // ---- one long gaussian list driving the sum down to its floor ----
    s.mode = MODE_GAUSSIAN; s.dims = 2'd3; s.gamma = WMax; s.inv = WMax;
    s.miss = rand_q16();
    apply_settings(s);
    idle_pct  = 16;
    stall_pct = 16;
    for (k = 0; k < 300; k++) begin
      o.resp  = ($urandom_range(19) == 0) ? cur.miss : QMax - 24'($urandom_range(0, 255));
      o.beta  = QMin + 24'($urandom_range(0, 65535));
      o.alpha = QMax - 24'($urandom_range(0, 65535));
      o.theta = QMin + 24'($urandom_range(0, 65535));
      o.pa = rand_q16(); o.pb = rand_q16(); o.pc = rand_q16();
      o.ia = rand_q16(); o.ib = rand_q16(); o.ic = rand_q16();
      o.last = (k == 299);
      send_obs(o);
    end
    wait_drained();

    // quiet tail: nothing more may come out
    stall_pct = 0;
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** latent_space_irt_loglik_accumulator: PASSED **");
    end else begin
      $display("** latent_space_irt_loglik_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
